// ===== hw/rtl/poly_pkg.sv =====
package poly_pkg;

    localparam int LIMB_W = 26;
    localparam int NLIMB  = 5;
    localparam logic [63:0] R_MASK_LO = 64'h0fff_fffc_0fff_ffff;
    localparam logic [63:0] R_MASK_HI = 64'h0fff_fffc_0fff_fffc;

    localparam logic [1:0] CFG_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_S_HIGH = 2'd3;

    typedef struct packed {
        logic [128:0] blk;
        logic         absorb;
        logic         last;
    } cmd_t;

    typedef struct packed {
        logic [63:0] r_lo;
        logic [63:0] r_hi;
        logic [63:0] s_lo;
        logic [63:0] s_hi;
    } key_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } tag_t;

endpackage

// ===== hw/rtl/poly_front.sv =====
module poly_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [63:0]       block_low,
    input  logic [63:0]       block_high,
    input  logic [4:0]        valid_bytes,
    input  logic              is_last,
    output logic              cmd_valid,
    output poly_pkg::cmd_t    cmd,
    input  logic              cmd_take
);

    poly_pkg::cmd_t mem_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [4:0]     n;
    logic [127:0]   data;
    logic [127:0]   kept;
    poly_pkg::cmd_t cls;
    logic           wr;
    logic           rd;

    // clip count, mask unused bytes, place padding bit
    always_comb
    begin
        n    = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
        data = {block_high, block_low};
        for (int k = 0; k < 16; k++)
        begin
            kept[8*k +: 8] = (5'(k) < n) ? data[8*k +: 8] : 8'h00;
        end
        cls.blk    = {1'b0, kept} | (129'd1 << {n, 3'b000});
        cls.absorb = (n != 5'd0);
        cls.last   = is_last;
    end

    assign full      = (cnt_reg == 2'd2);
    assign wr        = push && !full && (cls.absorb || cls.last);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign rd        = cmd_take && cmd_valid;
    assign cmd       = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + (wr ? 2'd1 : 2'd0) - (rd ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= cls;
        end
    end

endmodule

// ===== hw/rtl/poly_core.sv =====
module poly_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  poly_pkg::key_t    key,
    input  logic              cmd_valid,
    input  poly_pkg::cmd_t    cmd,
    output logic              cmd_take,
    output logic              tag_valid,
    output poly_pkg::tag_t    tag,
    input  logic              tag_room
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CARRY = 3'd2;
    localparam logic [2:0] ST_RED   = 3'd3;
    localparam logic [2:0] ST_FIN1  = 3'd4;
    localparam logic [2:0] ST_FIN2  = 3'd5;

    logic [2:0]   st_reg, st_next;
    logic [27:0]  h_reg [5];
    logic [27:0]  h_next [5];
    logic [28:0]  a_reg [5];
    logic [28:0]  a_next [5];
    logic [61:0]  d_reg [5];
    logic [61:0]  d_next [5];
    logic [2:0]   i_reg, i_next;
    logic [2:0]   j_reg, j_next;
    logic [35:0]  cy_reg, cy_next;
    logic         last_reg, last_next;
    logic [131:0] v_reg, v_next;

    logic [63:0]  rl, rh;
    logic [28:0]  r [5];
    logic [28:0]  s [5];
    logic [28:0]  c [5];
    logic [28:0]  coef;
    logic [57:0]  prod;
    logic [61:0]  t;
    logic [38:0]  t0;
    logic [27:0]  rc;
    logic [131:0] g;
    logic         sel;
    logic [127:0] fin;

    always_comb
    begin
        rl   = key.r_lo & poly_pkg::R_MASK_LO;
        rh   = key.r_hi & poly_pkg::R_MASK_HI;
        r[0] = {3'b0, rl[25:0]};
        r[1] = {3'b0, rl[51:26]};
        r[2] = {3'b0, rh[13:0], rl[63:52]};
        r[3] = {3'b0, rh[39:14]};
        r[4] = {5'b0, rh[63:40]};
        for (int k = 0; k < 5; k++)
        begin
            s[k] = (r[k] << 2) + r[k];
        end
        c[0] = {3'b0, cmd.blk[25:0]};
        c[1] = {3'b0, cmd.blk[51:26]};
        c[2] = {3'b0, cmd.blk[77:52]};
        c[3] = {3'b0, cmd.blk[103:78]};
        c[4] = {4'b0, cmd.blk[128:104]};
    end

    always_comb
    begin
        if (j_reg <= i_reg)
            coef = r[3'(i_reg - j_reg)];
        else
            coef = s[3'(i_reg + 3'd5 - j_reg)];
        prod = {29'b0, a_reg[j_reg]} * {29'b0, coef};
    end

    always_comb
    begin
        g   = v_reg + 132'd5;
        sel = (|g[131:130]) || (|v_reg[131:130]);
        fin = sel ? g[127:0] : v_reg[127:0];
        tag.lo = fin[63:0] + key.s_lo;
        tag.hi = fin[127:64] + key.s_hi + ((tag.lo < fin[63:0]) ? 64'd1 : 64'd0);
    end

    assign cmd_take  = (st_reg == ST_IDLE) && cmd_valid;
    assign tag_valid = (st_reg == ST_FIN2) && tag_room;

    always_comb
    begin
        st_next   = st_reg;
        h_next    = h_reg;
        a_next    = a_reg;
        d_next    = d_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        cy_next   = cy_reg;
        last_next = last_reg;
        v_next    = v_reg;
        t         = 62'd0;
        t0        = 39'd0;
        rc        = 28'd0;
        case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    last_next = cmd.last;
                    if (cmd.absorb)
                    begin
                        for (int k = 0; k < 5; k++)
                        begin
                            a_next[k] = {1'b0, h_reg[k]} + c[k];
                            d_next[k] = 62'd0;
                        end
                        i_next  = 3'd0;
                        j_next  = 3'd0;
                        st_next = ST_MUL;
                    end
                    else
                    begin
                        st_next = ST_FIN1;
                    end
                end
            end
            ST_MUL:
            begin
                d_next[i_reg] = d_reg[i_reg] + {4'b0, prod};
                if (j_reg == 3'd4)
                begin
                    j_next = 3'd0;
                    if (i_reg == 3'd4)
                    begin
                        i_next  = 3'd0;
                        cy_next = 36'd0;
                        st_next = ST_CARRY;
                    end
                    else
                    begin
                        i_next = i_reg + 3'd1;
                    end
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                end
            end
            ST_CARRY:
            begin
                t             = d_reg[i_reg] + {26'b0, cy_reg};
                cy_next       = t[61:26];
                h_next[i_reg] = {2'b0, t[25:0]};
                if (i_reg == 3'd4)
                    st_next = ST_RED;
                else
                    i_next = i_reg + 3'd1;
            end
            ST_RED:
            begin
                t0 = {11'b0, h_reg[0]} + {1'b0, cy_reg, 2'b0} + {3'b0, cy_reg};
                h_next[0] = {2'b0, t0[25:0]};
                rc = {15'b0, t0[38:26]};
                for (int k = 1; k < 4; k++)
                begin
                    rc        = h_reg[k] + rc;
                    h_next[k] = {2'b0, rc[25:0]};
                    rc        = {26'b0, rc[27:26]};
                end
                h_next[4] = h_reg[4] + rc;
                st_next   = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                v_next = {104'b0, h_reg[0]} + ({104'b0, h_reg[1]} << 26)
                       + ({104'b0, h_reg[2]} << 52) + ({104'b0, h_reg[3]} << 78)
                       + ({104'b0, h_reg[4]} << 104);
                st_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                if (tag_room)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        h_next[k] = 28'd0;
                    end
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            for (int k = 0; k < 5; k++)
            begin
                h_reg[k] <= 28'd0;
            end
        end
        else
        begin
            st_reg <= st_next;
            h_reg  <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        d_reg    <= d_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        cy_reg   <= cy_next;
        last_reg <= last_next;
        v_reg    <= v_next;
    end

endmodule

// ===== hw/rtl/poly_outq.sv =====
module poly_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  poly_pkg::tag_t    din,
    output logic              room,
    input  logic              pop,
    output logic              empty,
    output poly_pkg::tag_t    dout
);

    poly_pkg::tag_t mem_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           rd;

    assign room  = (cnt_reg != 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rd    = pop && !empty;
    assign dout  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + (wr ? 2'd1 : 2'd0) - (rd ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/poly1305_mac.sv =====
// Poly1305 authenticator. Load r and s through the config port, then push
// 16-byte blocks; the last one carries is_last and yields one tag. A front
// stage masks and pads each block into a two-entry queue, so push is taken
// while the core is busy. The core runs one 29x29 multiply a cycle over the
// 5x5 limb products: a full block is loaded, multiplied, carried and
// reduced, and the last item then passes a final reduction and the add of s.
// A zero-count item that is not last is dropped at the front. Tags wait in
// a two-entry output queue.
module poly1305_mac
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  valid_bytes,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high
);

    poly_pkg::key_t key_reg;
    poly_pkg::cmd_t cmd;
    poly_pkg::tag_t tag;
    poly_pkg::tag_t tag_out;
    logic           cmd_valid;
    logic           cmd_take;
    logic           tag_valid;
    logic           tag_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                poly_pkg::CFG_R_LOW:  key_reg.r_lo <= cfg_data;
                poly_pkg::CFG_R_HIGH: key_reg.r_hi <= cfg_data;
                poly_pkg::CFG_S_LOW:  key_reg.s_lo <= cfg_data;
                poly_pkg::CFG_S_HIGH: key_reg.s_hi <= cfg_data;
                default:              key_reg      <= key_reg;
            endcase
        end
    end

    poly_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .block_low   (block_low),
        .block_high  (block_high),
        .valid_bytes (valid_bytes),
        .is_last     (is_last),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    poly_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .tag_valid (tag_valid),
        .tag       (tag),
        .tag_room  (tag_room)
    );

    poly_outq u_outq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tag_valid),
        .din   (tag),
        .room  (tag_room),
        .pop   (pop),
        .empty (empty),
        .dout  (tag_out)
    );

    assign tag_low  = tag_out.lo;
    assign tag_high = tag_out.hi;

endmodule
